// ===== rtl/bnc_pkg.sv =====
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types, field widths and helpers of the box neighbor counter.
// ----------------------------------------------------------------------------
package bnc_pkg;

	localparam int MAX_GRAINS_DEF = 1024;
	localparam int COORD_BITS_DEF = 24;

	localparam int SLOT_W  = 10;
	localparam int QUERY_W = 10;
	localparam int COUNT_W = 11;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	// result beat: grain_slot, neighbor_count, zero pad up to whole bytes
	localparam int OUT_W   = ((SLOT_W + COUNT_W + 7) / 8) * 8;
	localparam int OUT_PAD = OUT_W - SLOT_W - COUNT_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// saturating increment of a neighbor count
	function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] cnt, logic en);
		logic [COUNT_W-1:0] res;
		res = cnt;
		if (en && (cnt != COUNT_MAX)) begin
			res = cnt + COUNT_W'(1);
		end
		return res;
	endfunction

endpackage

// ===== rtl/box_neighbor_counter.sv =====
// ----------------------------------------------------------------------------
// box_neighbor_counter
// Grain centroid table with box neighbor counting, one stored grain per cycle.
// ----------------------------------------------------------------------------
// Input beats arrive on s_*: s_tuser carries the operation (load, query,
// clear), s_tdata the centroid, the diameter and the query slot. Each beat
// gives exactly one result beat on m_*: the grain slot and count in
// m_tdata, the status code in m_tuser. cfg_* writes the flat mode bit and
// is always ready; write it only while no beat is in flight.
// A load into slot s sweeps stored slots 0..s through one compare unit, one
// slot per cycle off the single read port of the grain memory; a load into a
// full table skips the sweep. A query reads the count memory in S_QRD before
// its result; clear, unused codes and a query of an unloaded slot go straight
// to S_OUT. Only one beat is worked on at a time: s_tready is low from the
// accept until the result is in the output register.
// The output register lets a new beat be accepted while the previous result
// still waits on m_tready; a stalled result holds and the next one waits.
// Reset empties the table (fill level zero) and clears flat mode; the grain
// and count memories are not swept, an entry is only read after its load.
// ----------------------------------------------------------------------------
module box_neighbor_counter #(
	parameter int MAX_GRAINS = bnc_pkg::MAX_GRAINS_DEF,
	parameter int COORD_BITS = bnc_pkg::COORD_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// x_pos, y_pos, z_pos, diameter, query_index, zero pad
	input  logic [((4*COORD_BITS+bnc_pkg::QUERY_W+7)/8)*8-1:0] s_tdata,
	// operation
	input  logic [bnc_pkg::OP_W-1:0]                    s_tuser,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// grain_slot, neighbor_count, zero pad
	output logic [bnc_pkg::OUT_W-1:0]                   m_tdata,
	// status
	output logic [bnc_pkg::STAT_W-1:0]                  m_tuser,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic                                        cfg_data
);
	import bnc_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int SW   = $clog2(MAX_GRAINS);
	localparam int FW   = SW + 1;
	localparam int QCW  = (FW > QUERY_W) ? FW : QUERY_W;
	localparam int SOW  = (SW > SLOT_W) ? SW : SLOT_W;
	localparam int ENTW = 4 * CB;
	localparam logic [FW-1:0] FILL_MAX = FW'(MAX_GRAINS);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SWEEP = 5'b00010,
		S_DRAIN = 5'b00100,
		S_QRD   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	function automatic logic [CB:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
		logic [CB:0] ab;
		logic [CB:0] ba;
		ab = {a[CB-1], a} - {b[CB-1], b};
		ba = {b[CB-1], b} - {a[CB-1], a};
		return ab[CB] ? ba : ab;
	endfunction

	state_t state_q;
	logic   flat_q;
	logic [FW-1:0] fill_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] idx_q;
	logic [COUNT_W-1:0] acc_q;

	logic [CB-1:0] nx_q, ny_q, nz_q, nd_q;

	logic [ENTW-1:0]    crd_mem [MAX_GRAINS];
	logic [COUNT_W-1:0] cnt_mem [MAX_GRAINS];

	// sweep pipeline
	logic               v_s1, last_s1;
	logic [SW-1:0]      j_s1;
	logic [ENTW-1:0]    crd_s1;
	logic [COUNT_W-1:0] cnt_s1;

	logic               v_s2, last_s2;
	logic [SW-1:0]      j_s2;
	logic [CB:0]        ax_s2, ay_s2, az_s2;
	logic [CB-1:0]      dj_s2;
	logic [COUNT_W-1:0] cnt_s2;

	logic [SLOT_W-1:0]  res_slot_q;
	logic [COUNT_W-1:0] res_cnt_q;
	status_t            res_stat_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic [STAT_W-1:0]  m_tuser_q;

	logic          in_acc;
	op_t           in_op;
	logic [CB-1:0] in_x, in_y, in_z, in_d;
	logic [QUERY_W-1:0] in_q;
	logic [QCW-1:0] q_ext;
	logic          q_ok;
	logic          full;
	logic          out_load;

	logic [SW-1:0]      cnt_raddr;
	logic               cnt_we;
	logic [SW-1:0]      cnt_waddr;
	logic [COUNT_W-1:0] cnt_wdata;
	logic               hit_new, hit_old;
	logic [COUNT_W-1:0] acc_a, acc_next;
	logic [SOW-1:0]     slot_ext;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign in_acc = s_tvalid && s_tready;
	assign in_op  = op_t'(s_tuser);
	assign in_x   = s_tdata[CB-1:0];
	assign in_y   = s_tdata[2*CB-1:CB];
	assign in_z   = s_tdata[3*CB-1:2*CB];
	assign in_d   = s_tdata[4*CB-1:3*CB];
	assign in_q   = s_tdata[4*CB+QUERY_W-1:4*CB];
	assign q_ext  = QCW'(in_q);
	assign q_ok   = (q_ext < QCW'(fill_q));
	assign full   = (fill_q == FILL_MAX);
	assign slot_ext = SOW'(slot_q);

	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	// count read port: query slot while idle, sweep slot otherwise
	assign cnt_raddr = (state_q == S_IDLE) ? q_ext[SW-1:0] : idx_q;

	// compare unit, last stage of the sweep
	always_comb begin
		hit_new  = (ax_s2 < {1'b0, nd_q}) && (ay_s2 < {1'b0, nd_q})
			&& (az_s2 < {1'b0, nd_q});
		hit_old  = (ax_s2 < {1'b0, dj_s2}) && (ay_s2 < {1'b0, dj_s2})
			&& (az_s2 < {1'b0, dj_s2});
		acc_a    = sat_inc(acc_q, hit_new);
		// the new grain against itself bumps its own count a second time
		acc_next = last_s2 ? sat_inc(acc_a, hit_old) : acc_a;
		cnt_we   = v_s2;
		cnt_waddr = j_s2;
		cnt_wdata = last_s2 ? acc_next : sat_inc(cnt_s2, hit_old);
	end

	// memories
	always_ff @(posedge clk) begin
		if (in_acc && (in_op == OP_LOAD) && !full) begin
			crd_mem[fill_q[SW-1:0]] <= s_tdata[ENTW-1:0];
		end
		crd_s1 <= crd_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_s1 <= cnt_mem[cnt_raddr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			flat_q     <= 1'b0;
			fill_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				flat_q <= cfg_data;
			end
			v_s1 <= (state_q == S_SWEEP);
			v_s2 <= v_s1;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_op)
							OP_LOAD: begin
								if (full) begin
									state_q <= S_OUT;
								end else begin
									fill_q  <= fill_q + FW'(1);
									state_q <= S_SWEEP;
								end
							end
							OP_QUERY: begin
								state_q <= q_ok ? S_QRD : S_OUT;
							end
							OP_CLEAR: begin
								fill_q  <= '0;
								state_q <= S_OUT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (idx_q == slot_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= S_OUT;
					end
				end
				S_QRD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		j_s1    <= idx_q;
		last_s1 <= (idx_q == slot_q);

		j_s2    <= j_s1;
		last_s2 <= last_s1;
		ax_s2   <= abs_diff(nx_q, crd_s1[CB-1:0]);
		ay_s2   <= abs_diff(ny_q, crd_s1[2*CB-1:CB]);
		az_s2   <= flat_q ? '0 : abs_diff(nz_q, crd_s1[3*CB-1:2*CB]);
		dj_s2   <= crd_s1[4*CB-1:3*CB];
		cnt_s2  <= cnt_s1;

		if (v_s2) begin
			acc_q <= acc_next;
		end
		if (state_q == S_SWEEP) begin
			idx_q <= idx_q + SW'(1);
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					res_slot_q <= '0;
					res_cnt_q  <= '0;
					res_stat_q <= ST_OK;
					unique case (in_op)
						OP_LOAD: begin
							if (full) begin
								res_stat_q <= ST_FULL;
							end else begin
								slot_q <= fill_q[SW-1:0];
								idx_q  <= '0;
								acc_q  <= '0;
								nx_q   <= in_x;
								ny_q   <= in_y;
								nz_q   <= in_z;
								nd_q   <= in_d;
							end
						end
						OP_QUERY: begin
							res_slot_q <= in_q;
							if (!q_ok) begin
								res_stat_q <= ST_EMPTY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DRAIN: begin
				if (v_s2 && last_s2) begin
					res_slot_q <= slot_ext[SLOT_W-1:0];
					res_cnt_q  <= acc_next;
				end
			end
			S_QRD: begin
				res_cnt_q <= cnt_s1;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			m_tdata_q <= {{OUT_PAD{1'b0}}, res_cnt_q, res_slot_q};
			m_tuser_q <= res_stat_q;
		end
	end

endmodule

// ===== rtl/bnc_checker.sv =====
// ----------------------------------------------------------------------------
// bnc_checker
// Port-level checks of the box neighbor counter, bound to the top level.
// ----------------------------------------------------------------------------
module bnc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bnc_pkg::OUT_W-1:0]      m_tdata,
	input logic [bnc_pkg::STAT_W-1:0]     m_tuser
);
	import bnc_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one beat in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous beat in work");

	// refused load carries slot zero and count zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[SLOT_W+COUNT_W-1:0] == '0))
		else $error("table full result with nonzero payload");

	// query of an unloaded slot reports no neighbors
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[SLOT_W+COUNT_W-1:SLOT_W] == '0))
		else $error("empty slot result with nonzero count");

endmodule

bind box_neighbor_counter bnc_checker u_bnc_checker (.*);
